// ===== rtl/barometric_pressure_compensation_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation core
// Shared property wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication.
`define BPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compensation core: same-cycle check failed");

// Next-cycle implication.
`define BPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compensation core: next-cycle check failed");

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, constants and stage counts shared by the compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int RAW_W      = 20;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 88;
  localparam int CFG_W      = 48;
  localparam int CFG_ADDR_W = 2;

  // Stage counts of the units
  localparam int TEMP_LAT  = 5;
  localparam int FRONT_LAT = 8;
  localparam int DIV_LAT   = 66;
  localparam int BACK_LAT  = 6;
  localparam int TEMP_DLY  = FRONT_LAT + DIV_LAT + BACK_LAT;

  localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic [11:0]        NUM_SCALE   = 12'd3125;
  localparam logic [63:0]        DEN_BIAS    = 64'h0000_8000_0000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TEMP       = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_MID  = 2'd2,
    CFG_PRESS_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_temp.sv =====
// ----------------------------------------------------------------------------
// bpc_temp
// Five-stage temperature path: fine temperature and hundredths of a degree.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_temp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                in_valid,
  input  wire logic [19:0]         raw_temperature,
  input  wire bpc_pkg::coeff_t     coeff,
  output logic                     out_valid,
  output logic signed [31:0]       fine,
  output logic signed [23:0]       centi
);
  import bpc_pkg::*;

  logic [TEMP_LAT-1:0] vld;

  logic signed [17:0] a_diff;
  logic signed [16:0] d_diff;
  logic signed [31:0] a_word;
  logic [31:0]        dd_word;
  logic signed [31:0] lin;
  logic signed [31:0] xt3;
  logic signed [31:0] fine_s4;

  logic signed [17:0] a_diff_next;
  logic signed [16:0] d_diff_next;
  logic signed [33:0] prod_a;
  logic signed [33:0] prod_dd;
  logic signed [31:0] lin_next;
  logic signed [35:0] prod_x;
  logic signed [31:0] quad;
  logic [31:0]        scaled;

  assign a_diff_next = $signed({1'b0, raw_temperature[19:3]})
                     - $signed({1'b0, coeff.t1, 1'b0});
  assign d_diff_next = $signed({1'b0, raw_temperature[19:4]})
                     - $signed({1'b0, coeff.t1});
  assign prod_a   = a_diff * $signed(coeff.t2);
  assign prod_dd  = d_diff * d_diff;
  assign lin_next = a_word >>> 11;
  assign prod_x   = $signed(dd_word[31:12]) * $signed(coeff.t3);
  assign quad     = xt3 >>> 14;
  // fine * 5 + 128, then the arithmetic shift by 8 keeps bits 31:8
  assign scaled   = {fine_s4[29:0], 2'b00} + fine_s4 + 32'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TEMP_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff  <= a_diff_next;
      d_diff  <= d_diff_next;
      a_word  <= prod_a[31:0];
      dd_word <= prod_dd[31:0];
      lin     <= lin_next;
      xt3     <= prod_x[31:0];
      fine_s4 <= lin + quad;
      fine    <= fine_s4;
      centi   <= scaled[31:8];
    end
  end

  assign out_valid = vld[TEMP_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/bpc_pfront.sv =====
// ----------------------------------------------------------------------------
// bpc_pfront
// Eight-stage pressure front end: dividend and divisor of the pressure term.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_pfront (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic signed [31:0] fine,
  input  wire logic [19:0]       raw_pressure,
  input  wire bpc_pkg::coeff_t   coeff,
  output logic                   out_valid,
  output logic [63:0]            num,
  output logic [63:0]            den
);
  import bpc_pkg::*;

  logic [FRONT_LAT-1:0] vld;

  logic [20:0] praw [0:4];

  // stage 1
  logic signed [32:0] v;
  // stage 2
  logic [63:0]        vv;
  logic signed [48:0] vp5;
  logic signed [48:0] vp2;
  // stage 3
  logic signed [48:0] lo6, hi6, lo3, hi3;
  logic signed [48:0] vp5_s3, vp2_s3;
  // stage 4
  logic [63:0]        prod6, epart;
  logic signed [63:0] prod3;
  logic signed [48:0] vp2_s4;
  // stage 5
  logic [63:0]        e, den0;
  // stage 6
  logic [63:0]        x, t;
  // stage 7
  logic [47:0]        xlo_p, xhi_p;
  logic [43:0]        tlo_p, thi_p;

  logic signed [65:0] prod_vv;
  logic signed [63:0] prod3_sh;
  logic signed [63:0] den_full;
  logic signed [63:0] den_sh;

  assign prod_vv  = v * v;
  assign prod3_sh = prod3 >>> 8;
  assign den_full = {16'd0, xlo_p} + {xhi_p[31:0], 32'd0};
  assign den_sh   = den_full >>> 33;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: offset fine temperature, invert raw pressure
      v       <= {fine[31], fine} - FINE_OFFSET;
      praw[0] <= PRESS_BASE - {1'b0, raw_pressure};
      for (int i = 1; i < 5; i++) begin
        praw[i] <= praw[i-1];
      end
      // stage 2: square and linear terms
      vv  <= prod_vv[63:0];
      vp5 <= v * $signed(coeff.p5);
      vp2 <= v * $signed(coeff.p2);
      // stage 3: square times coefficients, split into 32-bit halves
      lo6    <= $signed({1'b0, vv[31:0]}) * $signed(coeff.p6);
      hi6    <= $signed({1'b0, vv[63:32]}) * $signed(coeff.p6);
      lo3    <= $signed({1'b0, vv[31:0]}) * $signed(coeff.p3);
      hi3    <= $signed({1'b0, vv[63:32]}) * $signed(coeff.p3);
      vp5_s3 <= vp5;
      vp2_s3 <= vp2;
      // stage 4: join halves
      prod6  <= {{15{lo6[48]}}, lo6} + {hi6[31:0], 32'd0};
      prod3  <= {{15{lo3[48]}}, lo3} + {hi3[31:0], 32'd0};
      epart  <= {{15{vp5_s3[48]}}, vp5_s3} << 17;
      vp2_s4 <= vp2_s3;
      // stage 5
      e    <= prod6 + epart + ({{48{coeff.p4[15]}}, coeff.p4} << 35);
      den0 <= prod3_sh + ({{15{vp2_s4[48]}}, vp2_s4} << 12);
      // stage 6
      x <= DEN_BIAS + den0;
      t <= ({43'd0, praw[4]} << 31) - e;
      // stage 7: scale by P1 and by 3125 in halves
      xlo_p <= x[31:0] * coeff.p1;
      xhi_p <= x[63:32] * coeff.p1;
      tlo_p <= t[31:0] * NUM_SCALE;
      thi_p <= t[63:32] * NUM_SCALE;
      // stage 8
      den <= den_sh;
      num <= {20'd0, tlo_p} + {thi_p[31:0], 32'd0};
    end
  end

  assign out_valid = vld[FRONT_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Signed 64-bit divider, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             out_valid,
  output logic [63:0]      quot,
  output logic             den_zero
);
  import bpc_pkg::*;

  localparam int STEPS = 64;

  logic [63:0] rem [0:STEPS];
  logic [63:0] dvd [0:STEPS];
  logic [63:0] dsr [0:STEPS];
  logic        neg [0:STEPS];
  logic        vld [0:STEPS];
  logic        vld_out;

  // Operand magnitudes and result sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= '0;
      dvd[0] <= num[63] ? (64'd0 - num) : num;
      dsr[0] <= den[63] ? (64'd0 - den) : den;
      neg[0] <= num[63] ^ den[63];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        take;

    assign rem_sh = {rem[k], dvd[k][63]};
    assign diff   = rem_sh - {1'b0, dsr[k]};
    assign take   = ~diff[64];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= take ? diff[63:0] : rem_sh[63:0];
        dvd[k+1] <= {dvd[k][62:0], take};
        dsr[k+1] <= dsr[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  // Restore sign; most negative over minus one wraps back to itself
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (adv) begin
      vld_out <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot     <= neg[STEPS] ? (64'd0 - dvd[STEPS]) : dvd[STEPS];
      den_zero <= (dsr[STEPS] == 64'd0);
    end
  end

  assign out_valid = vld_out;

endmodule

`default_nettype wire

// ===== rtl/bpc_pback.sv =====
// ----------------------------------------------------------------------------
// bpc_pback
// Six-stage pressure back end: P7..P9 corrections and Q24.8 result.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_pback (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [63:0]     quot,
  input  wire logic            den_zero,
  input  wire bpc_pkg::coeff_t coeff,
  output logic                 out_valid,
  output logic [31:0]          pressure,
  output logic                 div_zero
);
  import bpc_pkg::*;

  logic [BACK_LAT-1:0] vld;
  logic [BACK_LAT-2:0] dz;

  logic [63:0] p1r, p2r, p3r, p4r;
  logic [63:0] q1r, q2r;
  logic signed [48:0] m9lo, m9hi, c8lo, c8hi;
  logic [63:0]        m9;
  logic signed [63:0] c8f;
  logic [63:0]        ll;
  logic [31:0]        lh, hl;
  logic [63:0]        c8r, c8r4;
  logic signed [63:0] c9f;
  logic [63:0]        sum;

  logic signed [63:0] q;
  logic [63:0]        lh_full, hl_full;
  logic signed [63:0] c8_sh;
  logic signed [63:0] c9_sh;

  assign q       = $signed(quot) >>> 13;
  assign lh_full = m9[31:0] * q2r[63:32];
  assign hl_full = m9[63:32] * q2r[31:0];
  assign c8_sh   = c8f >>> 19;
  assign c9_sh   = c9f >>> 25;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BACK_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dz <= {dz[BACK_LAT-3:0], den_zero};
      // stage 1: P9 * q and P8 * p in halves
      p1r  <= quot;
      q1r  <= q;
      m9lo <= $signed({1'b0, q[31:0]}) * $signed(coeff.p9);
      m9hi <= $signed({1'b0, q[63:32]}) * $signed(coeff.p9);
      c8lo <= $signed({1'b0, quot[31:0]}) * $signed(coeff.p8);
      c8hi <= $signed({1'b0, quot[63:32]}) * $signed(coeff.p8);
      // stage 2
      p2r <= p1r;
      q2r <= q1r;
      m9  <= {{15{m9lo[48]}}, m9lo} + {m9hi[31:0], 32'd0};
      c8f <= {{15{c8lo[48]}}, c8lo} + {c8hi[31:0], 32'd0};
      // stage 3: (P9 * q) * q, low 64 bits from three partial products
      p3r <= p2r;
      ll  <= m9[31:0] * q2r[31:0];
      lh  <= lh_full[31:0];
      hl  <= hl_full[31:0];
      c8r <= c8_sh;
      // stage 4
      p4r  <= p3r;
      c9f  <= ll + {lh + hl, 32'd0};
      c8r4 <= c8r;
      // stage 5
      sum <= p4r + c9_sh + c8r4;
      // stage 6: shift by 8 keeps bits 39:8, add P7 << 4
      pressure <= dz[BACK_LAT-2] ? 32'd0
                : sum[39:8] + {{12{coeff.p7[15]}}, coeff.p7, 4'd0};
      div_zero <= dz[BACK_LAT-2];
    end
  end

  assign out_valid = vld[BACK_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/barometric_pressure_compensation_core.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Temperature and pressure compensation of raw 20-bit converter readings.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per reading pair: raw_pressure in tdata[19:0],
//   raw_temperature in tdata[39:20]. m_axis returns one word per input word,
//   in order: temperature_centi, fine_temperature and pressure_q24_8 in
//   tdata, divide_by_zero in tuser.
//   Calibration goes through cfg_we / cfg_addr / cfg_wdata, one 48-bit
//   register per write; write it only while no word is in flight.
//   Throughput: one word per cycle while the receiver does not stall. The
//   path runs through 5 temperature stages, 8 front-end stages, 66 divider
//   stages and 6 back-end stages; the bit-per-stage divider accounts for
//   most of them.
//   Reset clears all valid bits and the calibration registers to zero.
//   When the receiver stalls, the whole pipeline holds in place; a skid
//   register takes one more word, then s_axis_tready drops until the
//   pipeline advances again.
// ----------------------------------------------------------------------------
`default_nettype none

`include "barometric_pressure_compensation_core_defines.svh"

module barometric_pressure_compensation_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // raw_pressure [19:0], raw_temperature [39:20]
  input  wire logic [bpc_pkg::IN_W-1:0]     s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // temperature_centi [23:0], fine_temperature [55:24], pressure_q24_8 [87:56]
  output logic [bpc_pkg::OUT_W-1:0]         m_axis_tdata,
  // divide_by_zero
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic                         cfg_we,
  input  wire logic [bpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bpc_pkg::CFG_W-1:0]    cfg_wdata
);
  import bpc_pkg::*;

  // Calibration registers
  logic [CFG_W-1:0] temp_coeffs;
  logic [CFG_W-1:0] press_coeffs_low;
  logic [CFG_W-1:0] press_coeffs_mid;
  logic [CFG_W-1:0] press_coeffs_high;
  coeff_t           coeff;

  // Skid and pipeline control
  logic            skid_valid;
  logic [IN_W-1:0] skid_data;
  logic            adv;
  logic            pipe_valid;
  logic [IN_W-1:0] pipe_data;

  logic               temp_valid;
  logic signed [31:0] fine;
  logic signed [23:0] centi;
  logic               front_valid;
  logic [63:0]        num, den;
  logic               div_valid;
  logic [63:0]        quot;
  logic               den_zero;
  logic [31:0]        pressure;

  logic [55:0]      tdly [0:TEMP_DLY-1];
  logic [RAW_W-1:0] praw_dly [0:TEMP_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_mid  <= '0;
      press_coeffs_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_TEMP:       temp_coeffs       <= cfg_wdata;
        CFG_PRESS_LOW:  press_coeffs_low  <= cfg_wdata;
        CFG_PRESS_MID:  press_coeffs_mid  <= cfg_wdata;
        CFG_PRESS_HIGH: press_coeffs_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the twelve calibration words
  assign coeff.t1 = temp_coeffs[15:0];
  assign coeff.t2 = temp_coeffs[31:16];
  assign coeff.t3 = temp_coeffs[47:32];
  assign coeff.p1 = press_coeffs_low[15:0];
  assign coeff.p2 = press_coeffs_low[31:16];
  assign coeff.p3 = press_coeffs_low[47:32];
  assign coeff.p4 = press_coeffs_mid[15:0];
  assign coeff.p5 = press_coeffs_mid[31:16];
  assign coeff.p6 = press_coeffs_mid[47:32];
  assign coeff.p7 = press_coeffs_high[15:0];
  assign coeff.p8 = press_coeffs_high[31:16];
  assign coeff.p9 = press_coeffs_high[47:32];

  // Advance every stage unless the output word is held by the receiver
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~skid_valid;
  assign pipe_valid    = skid_valid | s_axis_tvalid;
  assign pipe_data     = skid_valid ? skid_data : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (s_axis_tvalid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Park a word that arrives while the pipeline holds
  always_ff @(posedge clk) begin
    if (!adv && s_axis_tvalid && !skid_valid) begin
      skid_data <= s_axis_tdata;
    end
  end

  // Carry the raw pressure alongside the temperature path
  always_ff @(posedge clk) begin
    if (adv) begin
      praw_dly[0] <= pipe_data[19:0];
      for (int i = 1; i < TEMP_LAT; i++) begin
        praw_dly[i] <= praw_dly[i-1];
      end
    end
  end

  bpc_temp u_temp (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (pipe_valid),
    .raw_temperature (pipe_data[39:20]),
    .coeff           (coeff),
    .out_valid       (temp_valid),
    .fine            (fine),
    .centi           (centi)
  );

  bpc_pfront u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (temp_valid),
    .fine         (fine),
    .raw_pressure (praw_dly[TEMP_LAT-1]),
    .coeff        (coeff),
    .out_valid    (front_valid),
    .num          (num),
    .den          (den)
  );

  bpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .num       (num),
    .den       (den),
    .out_valid (div_valid),
    .quot      (quot),
    .den_zero  (den_zero)
  );

  bpc_pback u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .quot      (quot),
    .den_zero  (den_zero),
    .coeff     (coeff),
    .out_valid (m_axis_tvalid),
    .pressure  (pressure),
    .div_zero  (m_axis_tuser)
  );

  // Carry the temperature results alongside the pressure path
  always_ff @(posedge clk) begin
    if (adv) begin
      tdly[0] <= {fine, centi};
      for (int i = 1; i < TEMP_DLY; i++) begin
        tdly[i] <= tdly[i-1];
      end
    end
  end

  assign m_axis_tdata = {pressure, tdly[TEMP_DLY-1]};

  // A divide-by-zero result must carry zero pressure
  `BPC_ASSERT_IMP(a_dz_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[87:56] == 32'd0)
  // The skid fills only while the pipeline is held
  `BPC_ASSERT_IMP(a_skid_fill, $rose(skid_valid), !$past(adv))
  // A parked word drains as soon as the pipeline advances
  `BPC_ASSERT_NXT(a_skid_drain, skid_valid && adv, !skid_valid)

endmodule

`default_nettype wire
